// ----- rtl/vdm_pkg.sv -----
`timescale 1ns / 1ps
package vdm_pkg;

   localparam int MAX_FRAGMENTS = 8;
   localparam int ROW_LEN       = 2 * MAX_FRAGMENTS;
   localparam int SYM_W         = 16;
   localparam int IDX_W         = $clog2(ROW_LEN);
   localparam int LANE_W        = $clog2(MAX_FRAGMENTS);
   localparam int ORD_W         = $clog2(MAX_FRAGMENTS + 1);
   localparam int CSR_IDX_W     = 2;
   localparam int BIT_W         = $clog2(SYM_W);
   localparam int MUL_CNT_W     = $clog2(SYM_W + 1);

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PRIME = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAG  = 2'd1;

   typedef logic [MAX_FRAGMENTS-1:0][SYM_W-1:0] sym_array_type;

   typedef struct packed {
      logic [SYM_W-1:0] symbol_0;
      logic [SYM_W-1:0] symbol_1;
      logic [SYM_W-1:0] symbol_2;
      logic [SYM_W-1:0] symbol_3;
      logic [SYM_W-1:0] symbol_4;
      logic [SYM_W-1:0] symbol_5;
      logic [SYM_W-1:0] symbol_6;
      logic [SYM_W-1:0] symbol_7;
   } req_word_type;

   typedef struct packed {
      logic [SYM_W-1:0]  recovered_symbol;
      logic [LANE_W-1:0] position;
      logic              last;
      logic              status;
   } rsp_word_type;

   // per-lane row operation
   typedef enum logic [2:0] {
      LOP_NONE,
      LOP_BUILD,
      LOP_SWAP,
      LOP_SCALE,
      LOP_CAP,
      LOP_ELIM,
      LOP_DOT
   } lane_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_WAIT,
      ST_COMMIT,
      ST_PIV,
      ST_INV0,
      ST_SQ,
      ST_SQW,
      ST_ML,
      ST_MLW,
      ST_OUT
   } state_type;

   // broadcast from the sequencer to every lane
   typedef struct packed {
      lane_op_type       op;
      logic              start;
      logic              commit;
      logic [IDX_W-1:0]  idx;
      logic [IDX_W-1:0]  k;
      logic [ORD_W-1:0]  order;
      logic [SYM_W-1:0]  modulus;
      logic [LANE_W-1:0] c_lane;
      logic [LANE_W-1:0] piv_lane;
      logic [SYM_W-1:0]  bc0;
      logic [SYM_W-1:0]  bc1;
   } lane_ctl_type;

endpackage

// ----- rtl/vdm_channels.sv -----
`timescale 1ns / 1ps
interface vdm_req_if;
   logic                  valid;
   logic                  ready;
   vdm_pkg::req_word_type word;
   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

interface vdm_rsp_if;
   logic                  valid;
   logic                  ready;
   vdm_pkg::rsp_word_type word;
   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

// ----- rtl/vdm_mulmod.sv -----
`timescale 1ns / 1ps
// Interleaved modular multiply: one bit of b per cycle, MSB first.
// a must already be reduced below the modulus; b may be any 16-bit value.
module vdm_mulmod (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [vdm_pkg::SYM_W-1:0]  a,
   input  logic [vdm_pkg::SYM_W-1:0]  b,
   input  logic [vdm_pkg::SYM_W-1:0]  modulus,
   output logic [vdm_pkg::SYM_W-1:0]  result,
   output logic                       done
);
   logic [vdm_pkg::SYM_W-1:0]     a_ff, b_ff, acc_ff, acc_in;
   logic [vdm_pkg::MUL_CNT_W-1:0] cnt_ff;
   logic [vdm_pkg::SYM_W+1:0]     t, p1, p2;

   // acc = (2*acc + bit*a) mod p, value stays below 3p
   always_comb begin
      p1 = {2'b00, modulus};
      p2 = {1'b0, modulus, 1'b0};
      t  = {1'b0, acc_ff, 1'b0} + (b_ff[vdm_pkg::SYM_W-1] ? {2'b00, a_ff} : '0);
      if (t >= p2) begin
         t = t - p2;
      end else if (t >= p1) begin
         t = t - p1;
      end
      acc_in = t[vdm_pkg::SYM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= vdm_pkg::MUL_CNT_W'(vdm_pkg::SYM_W);
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= a;
         b_ff   <= b;
         acc_ff <= '0;
      end else if (cnt_ff != '0) begin
         b_ff   <= {b_ff[vdm_pkg::SYM_W-2:0], 1'b0};
         acc_ff <= acc_in;
      end
   end

   assign result = acc_ff;
   assign done   = (cnt_ff == '0);
endmodule

// ----- rtl/vdm_lane.sv -----
`timescale 1ns / 1ps
// One row of the augmented matrix with its own modular multiplier.
module vdm_lane (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [vdm_pkg::LANE_W-1:0]      lane_id,
   input  vdm_pkg::lane_ctl_type           ctl,
   input  vdm_pkg::sym_array_type          symbols,
   output logic [vdm_pkg::SYM_W-1:0]       rd_data,
   output logic                            done,
   output logic [vdm_pkg::SYM_W-1:0]       dot_result
);
   logic [vdm_pkg::SYM_W-1:0] row_ff [vdm_pkg::ROW_LEN];
   logic [vdm_pkg::SYM_W-1:0] pw_ff, f_ff, dot_ff;
   logic [vdm_pkg::SYM_W-1:0] mul_a, mul_b, mul_res, wr_val, build_val, dot_base;
   logic [vdm_pkg::SYM_W:0]   diff, dsum;
   logic                      we, is_c, is_piv;

   assign rd_data = row_ff[ctl.idx];
   assign is_c    = (lane_id == ctl.c_lane);
   assign is_piv  = (lane_id == ctl.piv_lane);

   // operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (ctl.op)
         vdm_pkg::LOP_BUILD: begin
            mul_a = pw_ff;
            mul_b = {{(vdm_pkg::SYM_W-vdm_pkg::LANE_W){1'b0}}, lane_id}
                    + vdm_pkg::SYM_W'(1);
         end
         vdm_pkg::LOP_SCALE: begin
            mul_a = ctl.bc0;
            mul_b = rd_data;
         end
         vdm_pkg::LOP_ELIM: begin
            mul_a = f_ff;
            mul_b = ctl.bc0;
         end
         vdm_pkg::LOP_DOT: begin
            mul_a = rd_data;
            mul_b = symbols[ctl.k[vdm_pkg::LANE_W-1:0]];
         end
         default: ;
      endcase
   end

   vdm_mulmod u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (ctl.start),
      .a       (mul_a),
      .b       (mul_b),
      .modulus (ctl.modulus),
      .result  (mul_res),
      .done    (done)
   );

   // row write value
   always_comb begin
      if (ctl.k == '0) begin
         build_val = vdm_pkg::SYM_W'(1);
      end else if ({1'b0, ctl.k} < {{(vdm_pkg::IDX_W+1-vdm_pkg::ORD_W){1'b0}}, ctl.order}) begin
         build_val = mul_res;
      end else if (ctl.idx == vdm_pkg::IDX_W'(ctl.order)
                   + {{(vdm_pkg::IDX_W-vdm_pkg::LANE_W){1'b0}}, lane_id}) begin
         build_val = vdm_pkg::SYM_W'(1);
      end else begin
         build_val = '0;
      end
      // row - f*pivot mod p, both terms below p
      if (rd_data >= mul_res) begin
         diff = {1'b0, rd_data} - {1'b0, mul_res};
      end else begin
         diff = {1'b0, rd_data} + {1'b0, ctl.modulus} - {1'b0, mul_res};
      end
      dot_base = (ctl.k == '0) ? '0 : dot_ff;
      dsum     = {1'b0, dot_base} + {1'b0, mul_res};
      if (dsum >= {1'b0, ctl.modulus}) begin
         dsum = dsum - {1'b0, ctl.modulus};
      end
      we     = 1'b0;
      wr_val = '0;
      case (ctl.op)
         vdm_pkg::LOP_BUILD: begin
            we     = ctl.commit;
            wr_val = build_val;
         end
         vdm_pkg::LOP_SWAP: begin
            we     = ctl.commit && (is_c || is_piv);
            wr_val = is_c ? ctl.bc1 : ctl.bc0;
         end
         vdm_pkg::LOP_SCALE: begin
            we     = ctl.commit && is_c;
            wr_val = mul_res;
         end
         vdm_pkg::LOP_ELIM: begin
            we     = ctl.commit && !is_c;
            wr_val = diff[vdm_pkg::SYM_W-1:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         row_ff[ctl.idx] <= wr_val;
      end
      if (ctl.commit && ctl.op == vdm_pkg::LOP_BUILD
          && {1'b0, ctl.k} < {{(vdm_pkg::IDX_W+1-vdm_pkg::ORD_W){1'b0}}, ctl.order}) begin
         pw_ff <= build_val;
      end
      if (ctl.commit && ctl.op == vdm_pkg::LOP_CAP) begin
         f_ff <= rd_data;
      end
      if (ctl.commit && ctl.op == vdm_pkg::LOP_DOT) begin
         dot_ff <= dsum[vdm_pkg::SYM_W-1:0];
      end
   end

   assign dot_result = dot_ff;
endmodule

// ----- rtl/vandermonde_erasure_decode_mod_p.sv -----
`timescale 1ns / 1ps
// Vandermonde erasure decoder over GF(p).
// req_ch carries one column word: one coded symbol per fragment (only the
// first m are used). rsp_ch returns m recovered symbols per column, position
// 0..m-1, last set on the final one. A singular generator (or p below two)
// gives a single word with status 1 for every column until reset or a
// csr write of p or m. csr_wr_en/csr_index/csr_wr_data write p (index 0)
// or m (1). The first column after reset or such a write builds and
// inverts the m x m matrix: eight row lanes, each with a bit-serial modular
// multiplier, eliminate in parallel; the pivot inverse is a Fermat power
// on a separate multiplier. This build is done once.
// After that a column runs the dot-product work (each step of the lanes is
// one serial multiply plus load and write), then hands out the words: the
// serial multiplier sets the rate. One column is in flight at a time;
// req_ch.ready is high only when the block is idle. A stalled receiver
// holds the current word and the block waits. Reset restores p=257, m=3
// and drops the inverse.
module vandermonde_erasure_decode_mod_p (
   input  logic                                clock,
   input  logic                                reset,
   vdm_req_if.sink                             req_ch,
   vdm_rsp_if.source                           rsp_ch,
   input  logic                                csr_wr_en,
   input  logic [vdm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [vdm_pkg::SYM_W-1:0]           csr_wr_data
);
   localparam int NL = vdm_pkg::MAX_FRAGMENTS;

   vdm_pkg::state_type        state_ff, state_in;
   vdm_pkg::lane_op_type      op_ff, op_in;
   vdm_pkg::lane_ctl_type     ctl;
   vdm_pkg::sym_array_type    sym_ff, sym_in;
   logic [vdm_pkg::SYM_W-1:0] mod_ff;
   logic [vdm_pkg::ORD_W-1:0] frag_ff, order;
   logic                      inv_ff, inv_in, sing_ff, sing_in, csr_hit;
   logic [vdm_pkg::IDX_W-1:0] k_ff, k_in, idx_ff, idx_in, lim_ff, lim_in;
   logic [vdm_pkg::IDX_W-1:0] two_m_m1, m_m1;
   logic [vdm_pkg::LANE_W-1:0] c_ff, c_in, piv_ff, piv_in, r_ff, r_in, piv_sel;
   logic [vdm_pkg::SYM_W-1:0] pw_ff, pw_in, x_ff, x_in, expo, fm_res, fm_b;
   logic [vdm_pkg::BIT_W-1:0] bit_ff, bit_in;
   logic                      fm_start, fm_done, piv_found;
   logic [vdm_pkg::SYM_W-1:0] lane_rd  [NL];
   logic [vdm_pkg::SYM_W-1:0] lane_dot [NL];
   logic                      lane_done [NL];
   logic [vdm_pkg::ORD_W:0]   two_m;

   // order clamp: 0 -> 1, above lane count -> lane count
   always_comb begin
      if (frag_ff == '0) begin
         order = vdm_pkg::ORD_W'(1);
      end else if (frag_ff > vdm_pkg::ORD_W'(NL)) begin
         order = vdm_pkg::ORD_W'(NL);
      end else begin
         order = frag_ff;
      end
      two_m    = {order, 1'b0} - 1'b1;
      two_m_m1 = two_m[vdm_pkg::IDX_W-1:0];
      m_m1     = vdm_pkg::IDX_W'(order - 1'b1);
      expo     = mod_ff - vdm_pkg::SYM_W'(2);
   end

   // configuration registers
   assign csr_hit = csr_wr_en && (csr_index == vdm_pkg::CSR_PRIME
                                  || csr_index == vdm_pkg::CSR_FRAG);
   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff  <= vdm_pkg::SYM_W'(257);
         frag_ff <= vdm_pkg::ORD_W'(3);
      end else if (csr_wr_en) begin
         case (csr_index)
            vdm_pkg::CSR_PRIME: mod_ff  <= csr_wr_data;
            vdm_pkg::CSR_FRAG:  frag_ff <= csr_wr_data[vdm_pkg::ORD_W-1:0];
            default: ;
         endcase
      end
   end

   // lane control broadcast
   always_comb begin
      ctl.op       = op_ff;
      ctl.start    = (state_ff == vdm_pkg::ST_LOAD);
      ctl.commit   = (state_ff == vdm_pkg::ST_COMMIT);
      ctl.idx      = idx_ff;
      ctl.k        = k_ff;
      ctl.order    = order;
      ctl.modulus  = mod_ff;
      ctl.c_lane   = c_ff;
      ctl.piv_lane = piv_ff;
      ctl.bc1      = lane_rd[piv_ff];
      case (op_ff)
         vdm_pkg::LOP_SCALE: ctl.bc0 = pw_ff;
         default:            ctl.bc0 = lane_rd[c_ff];
      endcase
   end

   for (genvar g = 0; g < NL; g++) begin : g_lane
      vdm_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .lane_id    (vdm_pkg::LANE_W'(g)),
         .ctl        (ctl),
         .symbols    (sym_ff),
         .rd_data    (lane_rd[g]),
         .done       (lane_done[g]),
         .dot_result (lane_dot[g])
      );
   end

   // pivot inverse by Fermat power
   assign fm_b = (state_ff == vdm_pkg::ST_SQ) ? pw_ff : x_ff;
   vdm_mulmod u_fermat (
      .clock   (clock),
      .reset   (reset),
      .start   (fm_start),
      .a       (pw_ff),
      .b       (fm_b),
      .modulus (mod_ff),
      .result  (fm_res),
      .done    (fm_done)
   );

   // first nonzero entry at or below the diagonal
   always_comb begin
      piv_found = 1'b0;
      piv_sel   = '0;
      for (int i = 0; i < NL; i++) begin
         if (!piv_found && vdm_pkg::LANE_W'(i) >= c_ff
             && vdm_pkg::ORD_W'(i) < order && lane_rd[i] != '0) begin
            piv_found = 1'b1;
            piv_sel   = vdm_pkg::LANE_W'(i);
         end
      end
   end

   always_comb begin
      sym_in[0] = req_ch.word.symbol_0;
      sym_in[1] = req_ch.word.symbol_1;
      sym_in[2] = req_ch.word.symbol_2;
      sym_in[3] = req_ch.word.symbol_3;
      sym_in[4] = req_ch.word.symbol_4;
      sym_in[5] = req_ch.word.symbol_5;
      sym_in[6] = req_ch.word.symbol_6;
      sym_in[7] = req_ch.word.symbol_7;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      k_in     = k_ff;
      idx_in   = idx_ff;
      lim_in   = lim_ff;
      c_in     = c_ff;
      piv_in   = piv_ff;
      r_in     = r_ff;
      pw_in    = pw_ff;
      x_in     = x_ff;
      bit_in   = bit_ff;
      inv_in   = inv_ff;
      sing_in  = sing_ff;
      fm_start = 1'b0;
      unique case (state_ff) inside
         vdm_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               if (sing_ff) begin
                  state_in = vdm_pkg::ST_OUT;
               end else if (inv_ff) begin
                  op_in    = vdm_pkg::LOP_DOT;
                  k_in     = '0;
                  idx_in   = vdm_pkg::IDX_W'(order);
                  lim_in   = m_m1;
                  state_in = vdm_pkg::ST_LOAD;
               end else if (mod_ff < vdm_pkg::SYM_W'(2)) begin
                  sing_in  = 1'b1;
                  state_in = vdm_pkg::ST_OUT;
               end else begin
                  op_in    = vdm_pkg::LOP_BUILD;
                  k_in     = '0;
                  idx_in   = '0;
                  lim_in   = two_m_m1;
                  state_in = vdm_pkg::ST_LOAD;
               end
            end
            r_in = '0;
         end
         vdm_pkg::ST_LOAD: state_in = vdm_pkg::ST_WAIT;
         vdm_pkg::ST_WAIT: begin
            if (lane_done[0]) begin
               state_in = vdm_pkg::ST_COMMIT;
            end
         end
         vdm_pkg::ST_COMMIT: begin
            if (k_ff != lim_ff) begin
               k_in     = k_ff + 1'b1;
               idx_in   = idx_ff + 1'b1;
               state_in = vdm_pkg::ST_LOAD;
            end else begin
               k_in   = '0;
               idx_in = '0;
               case (op_ff)
                  vdm_pkg::LOP_BUILD: begin
                     c_in     = '0;
                     state_in = vdm_pkg::ST_PIV;
                  end
                  vdm_pkg::LOP_SWAP: begin
                     idx_in   = {1'b0, c_ff};
                     state_in = vdm_pkg::ST_INV0;
                  end
                  vdm_pkg::LOP_SCALE: begin
                     op_in    = vdm_pkg::LOP_CAP;
                     idx_in   = {1'b0, c_ff};
                     lim_in   = '0;
                     state_in = vdm_pkg::ST_LOAD;
                  end
                  vdm_pkg::LOP_CAP: begin
                     op_in    = vdm_pkg::LOP_ELIM;
                     lim_in   = two_m_m1;
                     state_in = vdm_pkg::ST_LOAD;
                  end
                  vdm_pkg::LOP_ELIM: begin
                     if ({1'b0, c_ff} == m_m1) begin
                        inv_in   = 1'b1;
                        op_in    = vdm_pkg::LOP_DOT;
                        idx_in   = vdm_pkg::IDX_W'(order);
                        lim_in   = m_m1;
                        state_in = vdm_pkg::ST_LOAD;
                     end else begin
                        c_in     = c_ff + 1'b1;
                        idx_in   = {1'b0, c_ff + 1'b1};
                        state_in = vdm_pkg::ST_PIV;
                     end
                  end
                  default: begin
                     r_in     = '0;
                     state_in = vdm_pkg::ST_OUT;
                  end
               endcase
            end
         end
         vdm_pkg::ST_PIV: begin
            // idx_ff points at column c here
            if (!piv_found) begin
               sing_in  = 1'b1;
               state_in = vdm_pkg::ST_OUT;
            end else if (piv_sel != c_ff) begin
               piv_in   = piv_sel;
               op_in    = vdm_pkg::LOP_SWAP;
               k_in     = '0;
               idx_in   = '0;
               lim_in   = two_m_m1;
               state_in = vdm_pkg::ST_LOAD;
            end else begin
               piv_in   = piv_sel;
               state_in = vdm_pkg::ST_INV0;
            end
         end
         vdm_pkg::ST_INV0: begin
            x_in     = lane_rd[c_ff];
            pw_in    = vdm_pkg::SYM_W'(1);
            bit_in   = vdm_pkg::BIT_W'(vdm_pkg::SYM_W - 1);
            state_in = vdm_pkg::ST_SQ;
         end
         vdm_pkg::ST_SQ: begin
            fm_start = 1'b1;
            state_in = vdm_pkg::ST_SQW;
         end
         vdm_pkg::ST_ML: begin
            fm_start = 1'b1;
            state_in = vdm_pkg::ST_MLW;
         end
         vdm_pkg::ST_SQW, vdm_pkg::ST_MLW: begin
            if (fm_done) begin
               pw_in = fm_res;
               if (state_ff == vdm_pkg::ST_SQW && expo[bit_ff]) begin
                  state_in = vdm_pkg::ST_ML;
               end else if (bit_ff == '0) begin
                  op_in    = vdm_pkg::LOP_SCALE;
                  k_in     = '0;
                  idx_in   = '0;
                  lim_in   = two_m_m1;
                  state_in = vdm_pkg::ST_LOAD;
               end else begin
                  bit_in   = bit_ff - 1'b1;
                  state_in = vdm_pkg::ST_SQ;
               end
            end
         end
         vdm_pkg::ST_OUT: begin
            if (rsp_ch.ready) begin
               if (rsp_ch.word.last) begin
                  state_in = vdm_pkg::ST_IDLE;
               end else begin
                  r_in = r_ff + 1'b1;
               end
            end
         end
         default: state_in = vdm_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vdm_pkg::ST_IDLE;
         op_ff    <= vdm_pkg::LOP_NONE;
         inv_ff   <= 1'b0;
         sing_ff  <= 1'b0;
         k_ff     <= '0;
         idx_ff   <= '0;
         lim_ff   <= '0;
         c_ff     <= '0;
         piv_ff   <= '0;
         r_ff     <= '0;
         bit_ff   <= '0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         k_ff     <= k_in;
         idx_ff   <= idx_in;
         lim_ff   <= lim_in;
         c_ff     <= c_in;
         piv_ff   <= piv_in;
         r_ff     <= r_in;
         bit_ff   <= bit_in;
         if (csr_hit) begin
            inv_ff  <= 1'b0;
            sing_ff <= 1'b0;
         end else begin
            inv_ff  <= inv_in;
            sing_ff <= sing_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      pw_ff <= pw_in;
      x_ff  <= x_in;
      if (req_ch.valid && req_ch.ready) begin
         sym_ff <= sym_in;
      end
   end

   // handshake and result word
   assign req_ch.ready = (state_ff == vdm_pkg::ST_IDLE);
   assign rsp_ch.valid = (state_ff == vdm_pkg::ST_OUT);
   always_comb begin
      rsp_ch.word.status           = sing_ff;
      rsp_ch.word.recovered_symbol = sing_ff ? '0 : lane_dot[r_ff];
      rsp_ch.word.position         = sing_ff ? '0 : r_ff;
      rsp_ch.word.last             = sing_ff || ({1'b0, r_ff} == m_m1);
   end
endmodule
